/* rtl/three_class_heap_scheduler_macros.svh */
// assertion macros shared by the scheduler rtl
`ifndef THREE_CLASS_HEAP_SCHEDULER_MACROS_SVH
`define THREE_CLASS_HEAP_SCHEDULER_MACROS_SVH

// condition that holds at every clock edge out of reset
`define TCHS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TCHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tchs_pkg.sv */
// package with commands, class codes, status codes and defaults of the three class scheduler
`timescale 1ns / 1ps

package tchs_pkg;

	localparam int NUM_CLASSES = 3;

	// commands
	localparam logic [1:0] CMD_ADD        = 2'd0;
	localparam logic [1:0] CMD_SERVE_NEXT = 2'd1;
	localparam logic [1:0] CMD_SERVE_ID   = 2'd2;

	// class codes
	localparam logic [1:0] CLS_TOP    = 2'd0;
	localparam logic [1:0] CLS_MIDDLE = 2'd1;
	localparam logic [1:0] CLS_LOW    = 2'd2;

	// status codes
	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_SERVED  = 3'd2;
	localparam logic [2:0] ST_NONE    = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// parameter defaults
	localparam int CAPACITY_DEF   = 64;
	localparam int ID_BITS_DEF    = 16;
	localparam int SCORE_BITS_DEF = 16;

endpackage

/* rtl/three_class_heap_scheduler.sv */
// three class priority scheduler: three binary max-heaps in one shared memory
//
// usage: present command, entry_id, entry_class and entry_score with start high;
// the item is taken at a clock edge where start is high and busy is low. busy stays
// high until the result, which is shown for exactly one cycle with done high on
// status, served_id, served_score, served_class and the three class counts.
// the receiver cannot stall; results are never held back.
// memory: all heap entries sit in one single-port-read memory with a registered
// read, so the item time is set by the memory port:
//   add/update and serve-by-id scan the queued ids class by class, top first,
//   at one per cycle within a class; then the entry sifts up, then down, a
//   level at a time; serve-next reads the root of the first non-empty class.
// reset: all heaps empty and classes map to banks 0,1,2 at once; the memory
// itself is not cleared, only entries below a bank's fill are used.
`timescale 1ns / 1ps
`include "three_class_heap_scheduler_macros.svh"

module three_class_heap_scheduler
	import tchs_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int ID_BITS    = ID_BITS_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  command,
	input  logic [15:0] entry_id,
	input  logic [1:0]  entry_class,
	input  logic [15:0] entry_score,
	output logic        busy,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] served_id,
	output logic [15:0] served_score,
	output logic [1:0]  served_class,
	output logic [6:0]  top_count,
	output logic [6:0]  middle_count,
	output logic [6:0]  low_count
);

	localparam int DEPTH = NUM_CLASSES * CAPACITY;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(CAPACITY);
	localparam int FW    = $clog2(CAPACITY + 1);
	localparam int CW    = PW + 2;
	localparam int EW    = ID_BITS + SCORE_BITS;
	localparam logic [AW-1:0] CAP_A = AW'(CAPACITY);
	localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_SCAN      = 4'd1;
	localparam logic [3:0] S_ROOT_RD   = 4'd2;
	localparam logic [3:0] S_ROOT_DATA = 4'd3;
	localparam logic [3:0] S_REMOVE    = 4'd4;
	localparam logic [3:0] S_REM_DATA  = 4'd5;
	localparam logic [3:0] S_UP        = 4'd6;
	localparam logic [3:0] S_UP_CMP    = 4'd7;
	localparam logic [3:0] S_DN        = 4'd8;
	localparam logic [3:0] S_DN_L      = 4'd9;
	localparam logic [3:0] S_DN_R      = 4'd10;
	localparam logic [3:0] S_DONE      = 4'd11;

	typedef logic [NUM_CLASSES-1:0][1:0]    map_t;
	typedef logic [NUM_CLASSES-1:0][FW-1:0] fill_t;

	function automatic logic [AW-1:0] addr_of(input logic [1:0] bank, input logic [PW-1:0] pos);
		addr_of = AW'(bank) * CAP_A + AW'(pos);
	endfunction

	// one move-up step: lower class takes an empty upper slot
	function automatic map_t move_up(input map_t m, input fill_t f, input logic [1:0] u);
		logic [1:0] a;
		logic [1:0] b;
		map_t r;
		r = m;
		a = m[u];
		b = m[u + 2'd1];
		if (f[a] == '0 && f[b] != '0) begin
			r[u] = b;
			r[u + 2'd1] = a;
		end
		move_up = r;
	endfunction

	// heap memory, entries are {id, score}
	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	logic [3:0]            state_q;
	logic [1:0]            cmd_q;
	logic [ID_BITS-1:0]    id_q;
	logic [1:0]            cls_q;
	logic [SCORE_BITS-1:0] score_q;
	fill_t                 fill_q;
	map_t                  map_q;
	logic [1:0]            bank_q;
	logic [PW-1:0]         p_q;
	logic [ID_BITS-1:0]    e_id_q;
	logic [SCORE_BITS-1:0] e_score_q;
	logic                  bsel_q;
	logic [PW-1:0]         bidx_q;
	logic [EW-1:0]         bent_q;

	// id scan pipeline
	logic       iss_q;
	logic [1:0] sc_q;
	logic [FW-1:0] si_q;
	logic       vld_s1;
	logic [1:0] cls_s1;
	logic [PW-1:0] pos_s1;

	// result registers
	logic        done_q;
	logic [2:0]  st_q;
	logic [15:0] sid_q;
	logic [15:0] sscore_q;
	logic [1:0]  scls_q;
	logic [6:0]  cnt0_q;
	logic [6:0]  cnt1_q;
	logic [6:0]  cnt2_q;

	logic [ID_BITS-1:0]    rd_id;
	logic [SCORE_BITS-1:0] rd_score;
	assign rd_id    = rdata_q[EW-1:SCORE_BITS];
	assign rd_score = rdata_q[SCORE_BITS-1:0];

	// scan helpers
	logic [1:0] scan_bank;
	logic       scan_issue;
	logic       scan_hit;
	assign scan_bank  = map_q[sc_q];
	assign scan_issue = iss_q && (si_q < fill_q[scan_bank]);
	assign scan_hit   = vld_s1 && (rd_id == id_q);

	// heap geometry around the hole
	logic [FW-1:0] n_fill;
	logic [CW-1:0] left_c;
	logic [CW-1:0] right_c;
	logic [PW-1:0] parent;
	logic [FW-1:0] last;
	assign n_fill  = fill_q[bank_q];
	assign left_c  = {1'b0, p_q, 1'b1};
	assign right_c = CW'({p_q, 1'b0}) + CW'(2);
	assign parent  = PW'((p_q - PW'(1)) >> 1);
	assign last    = n_fill - FW'(1);

	// first non-empty class for serve-next
	logic       any_q;
	logic [1:0] first_cls;
	always_comb begin
		any_q = 1'b0;
		first_cls = CLS_TOP;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (fill_q[map_q[c]] != '0) begin
				any_q = 1'b1;
				first_cls = 2'(c);
			end
		end
	end

	// sift-down choice between hole entry and its children
	logic          cand_sel;
	logic [PW-1:0] cand_idx;
	logic [EW-1:0] cand_ent;
	logic          decide;
	logic          r_better;
	always_comb begin
		cand_sel = 1'b0;
		cand_idx = p_q;
		cand_ent = rdata_q;
		decide = 1'b0;
		r_better = 1'b0;
		case (state_q)
			S_DN_L: begin
				cand_sel = rd_score > e_score_q;
				cand_idx = left_c[PW-1:0];
				cand_ent = rdata_q;
				decide = !(right_c < CW'(n_fill));
			end
			S_DN_R: begin
				r_better = rd_score > (bsel_q ? bent_q[SCORE_BITS-1:0] : e_score_q);
				cand_sel = r_better || bsel_q;
				cand_idx = r_better ? right_c[PW-1:0] : bidx_q;
				cand_ent = r_better ? rdata_q : bent_q;
				decide = 1'b1;
			end
			default: begin
				decide = 1'b0;
			end
		endcase
	end

	// memory port control
	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = addr_of(bank_q, p_q);
		wdata = {e_id_q, e_score_q};
		case (state_q)
			S_SCAN: raddr = addr_of(scan_bank, si_q[PW-1:0]);
			S_ROOT_RD: raddr = addr_of(bank_q, '0);
			S_REMOVE: raddr = addr_of(bank_q, last[PW-1:0]);
			S_UP: raddr = addr_of(bank_q, parent);
			S_UP_CMP: begin
				if (rd_score < e_score_q) begin
					we = 1'b1;
					wdata = rdata_q;
				end
			end
			S_DN: begin
				if (left_c < CW'(n_fill)) begin
					raddr = addr_of(bank_q, left_c[PW-1:0]);
				end else begin
					we = 1'b1;
				end
			end
			S_DN_L, S_DN_R: begin
				raddr = addr_of(bank_q, right_c[PW-1:0]);
				if (decide) begin
					we = 1'b1;
					wdata = cand_sel ? cand_ent : {e_id_q, e_score_q};
				end
			end
			default: raddr = '0;
		endcase
	end

	// memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// class map after serve-next empties a class
	map_t map_next;
	always_comb begin
		map_next = map_q;
		if (cmd_q == CMD_SERVE_NEXT && st_q == ST_SERVED && n_fill == '0) begin
			map_next = move_up(map_next, fill_q, CLS_TOP);
			map_next = move_up(map_next, fill_q, CLS_MIDDLE);
			map_next = move_up(map_next, fill_q, CLS_TOP);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			map_q <= {CLS_LOW, CLS_MIDDLE, CLS_TOP};
			done_q <= 1'b0;
			iss_q <= 1'b0;
			vld_s1 <= 1'b0;
			st_q <= ST_NONE;
			cmd_q <= CMD_ADD;
			id_q <= '0;
			cls_q <= CLS_TOP;
			score_q <= '0;
			bank_q <= '0;
			p_q <= '0;
			e_id_q <= '0;
			e_score_q <= '0;
			bsel_q <= 1'b0;
			bidx_q <= '0;
			bent_q <= '0;
			sc_q <= CLS_TOP;
			si_q <= '0;
			cls_s1 <= CLS_TOP;
			pos_s1 <= '0;
			sid_q <= '0;
			sscore_q <= '0;
			scls_q <= CLS_TOP;
			cnt0_q <= '0;
			cnt1_q <= '0;
			cnt2_q <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						id_q <= ID_BITS'(entry_id);
						cls_q <= (entry_class > CLS_LOW) ? CLS_LOW : entry_class;
						score_q <= SCORE_BITS'(entry_score);
						sid_q <= '0;
						sscore_q <= '0;
						scls_q <= CLS_TOP;
						st_q <= ST_NONE;
						sc_q <= CLS_TOP;
						si_q <= '0;
						iss_q <= 1'b1;
						case (command)
							CMD_ADD, CMD_SERVE_ID: state_q <= S_SCAN;
							CMD_SERVE_NEXT: begin
								if (any_q) begin
									bank_q <= map_q[first_cls];
									scls_q <= first_cls;
									st_q <= ST_SERVED;
									state_q <= S_ROOT_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					// issue the next read of the ordered scan
					if (scan_issue) begin
						vld_s1 <= 1'b1;
						cls_s1 <= sc_q;
						pos_s1 <= si_q[PW-1:0];
						si_q <= si_q + FW'(1);
					end else if (iss_q) begin
						si_q <= '0;
						if (sc_q == CLS_LOW) begin
							iss_q <= 1'b0;
						end else begin
							sc_q <= sc_q + 2'd1;
						end
					end
					// compare the entry read last cycle
					if (scan_hit) begin
						vld_s1 <= 1'b0;
						iss_q <= 1'b0;
						bank_q <= map_q[cls_s1];
						p_q <= pos_s1;
						if (cmd_q == CMD_ADD) begin
							e_id_q <= id_q;
							e_score_q <= score_q;
							st_q <= ST_UPDATED;
							state_q <= S_UP;
						end else begin
							sid_q <= 16'(rd_id);
							sscore_q <= 16'(rd_score);
							scls_q <= cls_s1;
							st_q <= ST_SERVED;
							state_q <= S_REMOVE;
						end
					end else if (!iss_q && !vld_s1) begin
						if (cmd_q == CMD_ADD) begin
							bank_q <= map_q[cls_q];
							if (fill_q[map_q[cls_q]] >= CAP_F) begin
								st_q <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								p_q <= fill_q[map_q[cls_q]][PW-1:0];
								fill_q[map_q[cls_q]] <= fill_q[map_q[cls_q]] + FW'(1);
								e_id_q <= id_q;
								e_score_q <= score_q;
								st_q <= ST_ADDED;
								state_q <= S_UP;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_ROOT_RD: state_q <= S_ROOT_DATA;
				S_ROOT_DATA: begin
					sid_q <= 16'(rd_id);
					sscore_q <= 16'(rd_score);
					p_q <= '0;
					state_q <= S_REMOVE;
				end
				// last entry fills the hole
				S_REMOVE: begin
					fill_q[bank_q] <= last;
					if (FW'(p_q) == last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_REM_DATA;
					end
				end
				S_REM_DATA: begin
					e_id_q <= rd_id;
					e_score_q <= rd_score;
					state_q <= S_UP;
				end
				S_UP: begin
					state_q <= (p_q == '0) ? S_DN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (rd_score < e_score_q) begin
						p_q <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_DN;
					end
				end
				S_DN: begin
					state_q <= (left_c < CW'(n_fill)) ? S_DN_L : S_DONE;
				end
				S_DN_L, S_DN_R: begin
					if (decide) begin
						if (cand_sel) begin
							p_q <= cand_idx;
							state_q <= S_DN;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						bsel_q <= cand_sel;
						bidx_q <= cand_idx;
						bent_q <= cand_ent;
						state_q <= S_DN_R;
					end
				end
				S_DONE: begin
					map_q <= map_next;
					cnt0_q <= 7'(fill_q[map_next[CLS_TOP]]);
					cnt1_q <= 7'(fill_q[map_next[CLS_MIDDLE]]);
					cnt2_q <= 7'(fill_q[map_next[CLS_LOW]]);
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = st_q;
	assign served_id    = sid_q;
	assign served_score = sscore_q;
	assign served_class = scls_q;
	assign top_count    = cnt0_q;
	assign middle_count = cnt1_q;
	assign low_count    = cnt2_q;

	`TCHS_ASSERT_NEXT(a_one_result, done_q, !done_q, "two results for one item")
	`TCHS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`TCHS_ASSERT_ALWAYS(a_fill_cap, fill_q[0] <= CAP_F && fill_q[1] <= CAP_F && fill_q[2] <= CAP_F, "heap fill above capacity")
	`TCHS_ASSERT_ALWAYS(a_map_perm, map_q[0] != map_q[1] && map_q[0] != map_q[2] && map_q[1] != map_q[2], "class map is not a permutation")

endmodule
